// File: hdl/srwr_pkg.sv
// Shared types and constants for the receive window resolver.
package srwr_pkg;

    // Operation codes carried by an input item
    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_WRITE  = 3'd1,
        OP_READ   = 3'd2,
        OP_MARK   = 3'd3,
        OP_EVAL   = 3'd4,
        OP_REPL   = 3'd5,
        OP_SHIFT  = 3'd6,
        OP_CLEAR  = 3'd7
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OLD       = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_FULL      = 3'd3,
        ST_BACK      = 3'd4
    } st_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_WINDOW_LENGTH  = 1'b0;
    localparam logic [0:0] CFG_SINR_THRESHOLD = 1'b1;

    localparam logic [31:0] WLEN_RESET = 32'd1000;
    localparam logic [15:0] THR_RESET  = 16'd256;

    // Evaluate emits at most this many hits
    localparam int MAX_RESULTS = 32;
    localparam int HIT_W       = 6;

    // Divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 7;

    // Overlap fraction of a fully covering partner (1.0 in Q48.16)
    localparam logic [63:0] FRAC_ONE = 64'h0000_0000_0001_0000;
    // One in the Q.24 interference scale
    localparam logic [63:0] INTERF_ONE = 64'h0000_0000_0100_0000;

    // One stored packet
    typedef struct packed {
        logic [31:0] t_start;
        logic [31:0] t_stop;
        logic [15:0] snr;
        logic [15:0] host;
        logic [15:0] packet;
    } entry_t;

    // How a partner entry bears on the entry under test
    typedef enum logic [1:0] {
        PR_SKIP = 2'd0,
        PR_FULL = 2'd1,
        PR_PART = 2'd2
    } pair_t;

    // Multiplier operand source
    typedef enum logic [1:0] {
        MS_FULL = 2'd0,
        MS_QUO  = 2'd1,
        MS_RHS  = 2'd2
    } msrc_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       rd_a;
        logic       rd_b;
        logic       wr_item;
        logic       wr_copy;
        logic       done_set;
        logic       occ_inc;
        logic       trim;
        logic       clear_all;
        logic       left_load;
        logic       interf_clr;
        logic       interf_add;
        logic       div_start;
        logic       mul_go;
        msrc_t      mul_src;
        logic       emit;
        st_t        status;
        logic       show_entry;
        logic       found;
        logic       last;
        logic [4:0] res_index;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t   op;
        logic  old_pkt;
        logic  idx_ok;
        logic  full;
        logic  back;
        logic  skip_i;
        logic  done_a;
        pair_t pair;
        logic  div_done;
        logic  mul_done;
        logic  hit;
        logic  match;
        logic  keep;
        logic  out_free;
    } stat_t;

endpackage

// File: hdl/srwr_div.sv
// Restoring divider, one quotient bit per cycle.
module srwr_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quo
);
    import srwr_pkg::*;

    logic [31:0]          rem_reg;
    logic [31:0]          den_reg;
    logic [63:0]          quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [32:0]          trial;
    logic                 ge;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};

    // Control: count the steps, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: hdl/srwr_datapath.sv
// Datapath: packet table, resolved flags, window registers, arithmetic and result register.
module srwr_datapath
#(
    parameter  int WINDOW_DEPTH = 32,
    localparam int AW = $clog2(WINDOW_DEPTH),
    localparam int CW = $clog2(WINDOW_DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [2:0]          op,
    input  logic [4:0]          index,
    input  logic [31:0]         start_time,
    input  logic [31:0]         end_time,
    input  logic [15:0]         snr,
    input  logic [15:0]         host_id,
    input  logic [15:0]         packet_id,
    input  logic [31:0]         new_left,
    input  srwr_pkg::cmd_t      cmd,
    input  logic [AW-1:0]       addr_a,
    input  logic [AW-1:0]       addr_b,
    input  logic [AW-1:0]       addr_w,
    input  logic [CW-1:0]       fill,
    output srwr_pkg::stat_t     stat,
    output logic [CW-1:0]       occ,
    output logic [AW-1:0]       item_addr,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [2:0]          status,
    output logic [4:0]          result_index,
    output logic                found,
    output logic                last,
    output logic [31:0]         entry_start,
    output logic [31:0]         entry_end,
    output logic [15:0]         entry_snr,
    output logic [15:0]         entry_host,
    output logic [15:0]         entry_packet,
    output logic                entry_resolved,
    output logic [5:0]          resolved_count,
    output logic                all_resolved
);
    import srwr_pkg::*;

    // Captured item
    op_t         op_reg;
    logic [4:0]  idx_reg;
    entry_t      item_reg;
    logic [31:0] nl_reg;

    // Table and its read ports
    entry_t      mem [WINDOW_DEPTH];
    entry_t      rda_reg;
    entry_t      rdb_reg;
    logic [AW-1:0] aq_reg;
    logic [AW-1:0] bq_reg;
    entry_t      wr_data;

    // Window state
    logic [WINDOW_DEPTH-1:0] done_reg;
    logic [WINDOW_DEPTH-1:0] done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] newcnt_reg;
    logic [CW-1:0] newcnt_next;
    logic [CW-1:0] occ_reg;
    logic [31:0]   left_reg;
    logic [31:0]   wlen_reg;
    logic [15:0]   thr_reg;
    logic [63:0]   interf_reg;

    // Multiplier, 64 by 16 bits over four 16-bit chunks
    logic [63:0] mul_a_reg;
    logic [15:0] mul_b_reg;
    logic [63:0] mul_acc_reg;
    logic [1:0]  mul_step_reg;
    logic        mul_busy_reg;
    logic        mul_done_reg;
    logic [31:0] mul_part;

    // Pair evaluation
    logic        x1;
    logic        x2;
    logic        x3;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] div_num;
    logic [31:0] div_den;
    logic        div_done;
    logic [63:0] div_quo;
    logic [63:0] lhs;

    // Output register
    logic        out_valid_reg;
    st_t         status_reg;
    logic [4:0]  res_idx_reg;
    logic        found_reg;
    logic        last_reg;
    entry_t      ent_reg;
    logic        ent_done_reg;
    logic [5:0]  rcount_reg;
    logic        allres_reg;

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg           <= op_t'(op);
            idx_reg          <= index;
            item_reg.t_start <= start_time;
            item_reg.t_stop  <= end_time;
            item_reg.snr     <= snr;
            item_reg.host    <= host_id;
            item_reg.packet  <= packet_id;
            nl_reg           <= new_left;
        end
    end

    assign item_addr = AW'(idx_reg);
    assign occ       = occ_reg;

    // Table: one write port, two registered read ports
    assign wr_data = cmd.wr_copy ? rda_reg : item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_item || cmd.wr_copy)
        begin
            mem[addr_w] <= wr_data;
        end
        if (cmd.rd_a)
        begin
            rda_reg <= mem[addr_a];
            aq_reg  <= addr_a;
        end
        if (cmd.rd_b)
        begin
            rdb_reg <= mem[addr_b];
            bq_reg  <= addr_b;
        end
    end

    // Resolved flags and count
    always_comb
    begin
        done_next   = done_reg;
        cnt_next    = cnt_reg;
        newcnt_next = newcnt_reg;
        if (cmd.clear_all)
        begin
            done_next = '0;
            cnt_next  = '0;
        end
        else if (cmd.trim)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
            begin
                if (CW'(k) >= fill)
                begin
                    done_next[k] = 1'b0;
                end
            end
            cnt_next = newcnt_reg;
        end
        else if (cmd.wr_item)
        begin
            if (done_reg[addr_w])
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            done_next[addr_w] = 1'b0;
        end
        else if (cmd.done_set)
        begin
            if (!done_reg[addr_w])
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            done_next[addr_w] = 1'b1;
        end
        else if (cmd.wr_copy)
        begin
            done_next[addr_w] = done_reg[aq_reg];
            if (done_reg[aq_reg])
            begin
                newcnt_next = newcnt_reg + 1'b1;
            end
        end
        if (cmd.left_load)
        begin
            newcnt_next = '0;
        end
    end

    // Window state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= '0;
            cnt_reg    <= '0;
            newcnt_reg <= '0;
            occ_reg    <= '0;
            left_reg   <= '0;
            wlen_reg   <= WLEN_RESET;
            thr_reg    <= THR_RESET;
        end
        else
        begin
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            newcnt_reg <= newcnt_next;
            if (cmd.clear_all)
            begin
                occ_reg <= '0;
            end
            else if (cmd.trim)
            begin
                occ_reg <= fill;
            end
            else if (cmd.occ_inc)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.left_load)
            begin
                left_reg <= nl_reg;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH:  wlen_reg <= cfg_data;
                    CFG_SINR_THRESHOLD: thr_reg  <= cfg_data[15:0];
                    default:            wlen_reg <= wlen_reg;
                endcase
            end
        end
    end

    // Overlap of partner B against entry A
    assign x1 = (rda_reg.t_start <= rdb_reg.t_start) && (rdb_reg.t_start < rda_reg.t_stop);
    assign x2 = (rda_reg.t_start < rdb_reg.t_stop) && (rdb_reg.t_stop <= rda_reg.t_stop);
    assign x3 = (rdb_reg.t_start <= rda_reg.t_start) && (rda_reg.t_stop <= rdb_reg.t_stop);
    assign lo = (rda_reg.t_start > rdb_reg.t_start) ? rda_reg.t_start : rdb_reg.t_start;
    assign hi = (rda_reg.t_stop < rdb_reg.t_stop) ? rda_reg.t_stop : rdb_reg.t_stop;

    // Fraction numerator wraps modulo 2^64 when the partner is reversed
    assign div_num = (64'(hi) - 64'(lo)) << 16;
    assign div_den = rda_reg.t_stop - rda_reg.t_start;

    srwr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Multiplier control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_step_reg <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.mul_go)
            begin
                mul_busy_reg <= 1'b1;
                mul_step_reg <= '0;
            end
            else if (mul_busy_reg)
            begin
                mul_step_reg <= mul_step_reg + 1'b1;
                if (mul_step_reg == 2'd3)
                begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    assign mul_part = mul_a_reg[15:0] * mul_b_reg;

    // Multiplier data: accumulate one chunk product per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            mul_acc_reg <= '0;
            unique case (cmd.mul_src)
                MS_FULL:
                begin
                    mul_a_reg <= FRAC_ONE;
                    mul_b_reg <= rdb_reg.snr;
                end
                MS_QUO:
                begin
                    mul_a_reg <= div_quo;
                    mul_b_reg <= rdb_reg.snr;
                end
                default:
                begin
                    mul_a_reg <= interf_reg + INTERF_ONE;
                    mul_b_reg <= thr_reg;
                end
            endcase
        end
        else if (mul_busy_reg)
        begin
            mul_acc_reg <= mul_acc_reg + (64'(mul_part) << {mul_step_reg, 4'b0000});
            mul_a_reg   <= mul_a_reg >> 16;
        end
    end

    // Interference sum
    always_ff @(posedge clk)
    begin
        if (cmd.interf_clr)
        begin
            interf_reg <= '0;
        end
        else if (cmd.interf_add)
        begin
            interf_reg <= interf_reg + mul_acc_reg;
        end
    end

    assign lhs = {24'b0, rda_reg.snr, 24'b0};

    // Status to the controller
    always_comb
    begin
        stat.op       = op_reg;
        stat.old_pkt  = item_reg.t_start < left_reg;
        stat.idx_ok   = 8'(idx_reg) < 8'(occ_reg);
        stat.full     = occ_reg == CW'(WINDOW_DEPTH);
        stat.back     = nl_reg < left_reg;
        stat.skip_i   = done_reg[aq_reg]
                     || ({1'b0, rda_reg.t_stop} > ({1'b0, left_reg} + {1'b0, wlen_reg}))
                     || (rda_reg.t_start < left_reg);
        stat.done_a   = done_reg[aq_reg];
        if (done_reg[bq_reg])
        begin
            stat.pair = PR_SKIP;
        end
        else if (x3)
        begin
            stat.pair = PR_FULL;
        end
        else if (x1 || x2)
        begin
            stat.pair = PR_PART;
        end
        else
        begin
            stat.pair = PR_SKIP;
        end
        stat.div_done = div_done;
        stat.mul_done = mul_done_reg;
        stat.hit      = lhs >= mul_acc_reg;
        stat.match    = (rda_reg.host == rdb_reg.host) && (rda_reg.packet == rdb_reg.packet);
        stat.keep     = rda_reg.t_stop >= left_reg;
        stat.out_free = !out_valid_reg || !out_stall;
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg   <= cmd.status;
            res_idx_reg  <= cmd.res_index;
            found_reg    <= cmd.found;
            last_reg     <= cmd.last;
            ent_reg      <= cmd.show_entry ? rda_reg : '0;
            ent_done_reg <= cmd.show_entry ? done_reg[aq_reg] : 1'b0;
            rcount_reg   <= 6'(cnt_reg);
            allres_reg   <= cnt_reg == occ_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_index   = res_idx_reg;
    assign found          = found_reg;
    assign last           = last_reg;
    assign entry_start    = ent_reg.t_start;
    assign entry_end      = ent_reg.t_stop;
    assign entry_snr      = ent_reg.snr;
    assign entry_host     = ent_reg.host;
    assign entry_packet   = ent_reg.packet;
    assign entry_resolved = ent_done_reg;
    assign resolved_count = rcount_reg;
    assign all_resolved   = allres_reg;

endmodule

// File: hdl/srwr_ctrl.sv
// Controller: sequences each operation over the datapath.
module srwr_ctrl
#(
    parameter  int WINDOW_DEPTH = 32,
    localparam int AW = $clog2(WINDOW_DEPTH),
    localparam int CW = $clog2(WINDOW_DEPTH + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  srwr_pkg::stat_t stat,
    input  logic [CW-1:0]   occ,
    input  logic [AW-1:0]   item_addr,
    output srwr_pkg::cmd_t  cmd,
    output logic [AW-1:0]   addr_a,
    output logic [AW-1:0]   addr_b,
    output logic [AW-1:0]   addr_w,
    output logic [CW-1:0]   fill
);
    import srwr_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_DECODE  = 20'h00002,
        S_EMIT    = 20'h00004,
        S_RD_WAIT = 20'h00008,
        S_EV_I    = 20'h00010,
        S_EV_ILD  = 20'h00020,
        S_EV_J    = 20'h00040,
        S_EV_JLD  = 20'h00080,
        S_EV_DIV  = 20'h00100,
        S_EV_MUL  = 20'h00200,
        S_EV_RHS  = 20'h00400,
        S_EV_HIT  = 20'h00800,
        S_EV_END  = 20'h01000,
        S_RP_I    = 20'h02000,
        S_RP_CHK  = 20'h04000,
        S_RP_J    = 20'h08000,
        S_RP_JLD  = 20'h10000,
        S_SH_RD   = 20'h20000,
        S_SH_WR   = 20'h40000,
        S_SH_FIN  = 20'h80000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CW-1:0]    i_reg;
    logic [CW-1:0]    i_next;
    logic [CW-1:0]    j_reg;
    logic [CW-1:0]    j_next;
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    n_next;
    logic             pend_reg;
    logic             pend_next;
    logic [4:0]       pidx_reg;
    logic [4:0]       pidx_next;
    logic [HIT_W-1:0] hits_reg;
    logic [HIT_W-1:0] hits_next;
    st_t              st_reg;
    st_t              st_next;

    assign in_stall = state_reg != S_IDLE;
    assign fill     = n_reg;
    assign addr_b   = AW'(j_reg);

    // Table addresses
    always_comb
    begin
        unique case (state_reg)
            S_DECODE: addr_a = item_addr;
            S_SH_RD:  addr_a = AW'(j_reg);
            default:  addr_a = AW'(i_reg);
        endcase
        unique case (state_reg)
            S_DECODE: addr_w = (stat.op == OP_ADD) ? AW'(occ) : item_addr;
            S_RP_JLD: addr_w = AW'(j_reg);
            default:  addr_w = AW'(n_reg);
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        hits_next  = hits_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                st_next    = ST_OK;
                state_next = S_EMIT;
                unique case (stat.op)
                    OP_ADD:
                    begin
                        if (stat.old_pkt)
                        begin
                            st_next = ST_OLD;
                        end
                        else if (stat.full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_item = 1'b1;
                            cmd.occ_inc = 1'b1;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (stat.old_pkt)
                        begin
                            st_next = ST_OLD;
                        end
                        else if (!stat.idx_ok)
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.wr_item = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (!stat.idx_ok)
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.rd_a   = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                    end
                    OP_MARK:
                    begin
                        if (!stat.idx_ok)
                        begin
                            st_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.done_set = 1'b1;
                        end
                    end
                    OP_EVAL:
                    begin
                        i_next     = '0;
                        hits_next  = '0;
                        pend_next  = 1'b0;
                        state_next = S_EV_I;
                    end
                    OP_REPL:
                    begin
                        i_next     = '0;
                        state_next = S_RP_I;
                    end
                    OP_SHIFT:
                    begin
                        if (stat.back)
                        begin
                            st_next = ST_BACK;
                        end
                        else
                        begin
                            cmd.left_load = 1'b1;
                            j_next        = '0;
                            n_next        = '0;
                            state_next    = S_SH_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = st_reg;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RD_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.show_entry = 1'b1;
                    cmd.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // Evaluate: outer loop over candidate entries
            S_EV_I:
            begin
                if (i_reg == occ)
                begin
                    state_next = S_EV_END;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_EV_ILD;
                end
            end

            S_EV_ILD:
            begin
                if (stat.skip_i)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_EV_I;
                end
                else
                begin
                    cmd.interf_clr = 1'b1;
                    j_next         = '0;
                    state_next     = S_EV_J;
                end
            end

            // Inner loop over partners
            S_EV_J:
            begin
                if (j_reg == occ)
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_src = MS_RHS;
                    state_next  = S_EV_RHS;
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = S_EV_JLD;
                end
            end

            S_EV_JLD:
            begin
                unique case (stat.pair)
                    PR_FULL:
                    begin
                        cmd.mul_go  = 1'b1;
                        cmd.mul_src = MS_FULL;
                        state_next  = S_EV_MUL;
                    end
                    PR_PART:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_EV_DIV;
                    end
                    default:
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_EV_J;
                    end
                endcase
            end

            S_EV_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_src = MS_QUO;
                    state_next  = S_EV_MUL;
                end
            end

            S_EV_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.interf_add = 1'b1;
                    j_next         = j_reg + 1'b1;
                    state_next     = S_EV_J;
                end
            end

            S_EV_RHS:
            begin
                if (stat.mul_done)
                begin
                    if (stat.hit)
                    begin
                        state_next = S_EV_HIT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EV_I;
                    end
                end
            end

            // Hold the newest hit; release the previous one as not last
            S_EV_HIT:
            begin
                if (!pend_reg || stat.out_free)
                begin
                    if (pend_reg)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.found     = 1'b1;
                        cmd.res_index = pidx_reg;
                    end
                    pend_next = 1'b1;
                    pidx_next = 5'(i_reg);
                    hits_next = hits_reg + 1'b1;
                    i_next    = i_reg + 1'b1;
                    if (hits_next == HIT_W'(MAX_RESULTS))
                    begin
                        state_next = S_EV_END;
                    end
                    else
                    begin
                        state_next = S_EV_I;
                    end
                end
            end

            S_EV_END:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.found     = pend_reg;
                    cmd.res_index = pend_reg ? pidx_reg : 5'd0;
                    cmd.last      = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // Replicas: outer loop over resolved entries
            S_RP_I:
            begin
                if (i_reg == occ)
                begin
                    st_next    = ST_OK;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_RP_CHK;
                end
            end

            S_RP_CHK:
            begin
                if (stat.done_a)
                begin
                    j_next     = '0;
                    state_next = S_RP_J;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RP_I;
                end
            end

            S_RP_J:
            begin
                if (j_reg == occ)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RP_I;
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = S_RP_JLD;
                end
            end

            S_RP_JLD:
            begin
                cmd.done_set = stat.match;
                j_next       = j_reg + 1'b1;
                state_next   = S_RP_J;
            end

            // Shift: compact surviving entries in order
            S_SH_RD:
            begin
                if (j_reg == occ)
                begin
                    state_next = S_SH_FIN;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                if (stat.keep)
                begin
                    cmd.wr_copy = 1'b1;
                    n_next      = n_reg + 1'b1;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_SH_RD;
            end

            S_SH_FIN:
            begin
                cmd.trim   = 1'b1;
                st_next    = ST_OK;
                state_next = S_EMIT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            pidx_reg  <= '0;
            hits_reg  <= '0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            pidx_reg  <= pidx_next;
            hits_reg  <= hits_next;
            st_reg    <= st_next;
        end
    end

endmodule

// File: hdl/sinr_receive_window_resolver_top.sv
// Top level of the receive window resolver: controller, datapath and checks.
//
// Input channel (in_valid / in_stall) carries one operation per item; the result
// channel (out_valid / out_stall) returns one result per item, or one per
// resolvable entry for evaluate, with last set on the final one.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// One item is worked at a time; in_stall is high until its results are queued.
// Add, write, mark and clear pass through decode and emit, read through decode and
// a read wait; replicas walk every stored entry and, for each resolved one, all
// partners; shift walks every stored entry once. Evaluate walks every entry pair:
// a covering partner goes to the chunked multiplier, a partial one through the
// divider and then the multiplier; each candidate ends with a threshold product.
// The divider sets the evaluate time.
// Results sit in an output register; a stalled result holds and the
// controller waits before placing the next one.
// Reset empties the table, sets the left edge to zero and loads the register
// defaults (window length 1000, threshold 1.0).
module sinr_receive_window_resolver_top
#(
    parameter int WINDOW_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [4:0]  index,
    input  logic [31:0] start_time,
    input  logic [31:0] end_time,
    input  logic [15:0] snr,
    input  logic [15:0] host_id,
    input  logic [15:0] packet_id,
    input  logic [31:0] new_left,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [4:0]  result_index,
    output logic        found,
    output logic        last,
    output logic [31:0] entry_start,
    output logic [31:0] entry_end,
    output logic [15:0] entry_snr,
    output logic [15:0] entry_host,
    output logic [15:0] entry_packet,
    output logic        entry_resolved,
    output logic [5:0]  resolved_count,
    output logic        all_resolved
);
    import srwr_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [CW-1:0] occ;
    logic [CW-1:0] fill;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_w;

    srwr_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .stat      (stat),
        .occ       (occ),
        .item_addr (item_addr),
        .cmd       (cmd),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .addr_w    (addr_w),
        .fill      (fill)
    );

    srwr_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .index          (index),
        .start_time     (start_time),
        .end_time       (end_time),
        .snr            (snr),
        .host_id        (host_id),
        .packet_id      (packet_id),
        .new_left       (new_left),
        .cmd            (cmd),
        .addr_a         (addr_a),
        .addr_b         (addr_b),
        .addr_w         (addr_w),
        .fill           (fill),
        .stat           (stat),
        .occ            (occ),
        .item_addr      (item_addr),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .result_index   (result_index),
        .found          (found),
        .last           (last),
        .entry_start    (entry_start),
        .entry_end      (entry_end),
        .entry_snr      (entry_snr),
        .entry_host     (entry_host),
        .entry_packet   (entry_packet),
        .entry_resolved (entry_resolved),
        .resolved_count (resolved_count),
        .all_resolved   (all_resolved)
    );

    // One item at a time: an accepted item blocks the next one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while another is in work");

    // Every result is either a hit or the closing result
    a_found_or_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found || last))
        else $error("result neither found nor last");

    // A non-hit result carries index zero
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (result_index == 5'd0))
        else $error("index set on a result without a hit");

    // An error status is a single closing result
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (last && !found))
        else $error("error status on a hit or non-final result");

    // The occupancy never runs past the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= CW'(WINDOW_DEPTH))
        else $error("occupancy beyond table depth");

endmodule
